// File: sv/brft_pkg.sv
// Package for the byte ring FIFO tokenizer: request codes, character constants,
// find status codes and the structs used by the top level and the scan unit.
// Depends on nothing.
package brft_pkg;

   // Request action codes.
   localparam logic [2:0] ACT_PUT   = 3'd0;
   localparam logic [2:0] ACT_GET   = 3'd1;
   localparam logic [2:0] ACT_PEEK  = 3'd2;
   localparam logic [2:0] ACT_SKIP  = 3'd3;
   localparam logic [2:0] ACT_FIND  = 3'd4;
   localparam logic [2:0] ACT_TOKEN = 3'd5;

   // Find status codes.
   localparam logic [1:0] FIND_FOUND = 2'd0;
   localparam logic [1:0] FIND_EMPTY = 2'd1;
   localparam logic [1:0] FIND_NONE  = 2'd2;

   // Character constants.
   localparam logic [7:0] STAR_CHAR  = 8'h2A;
   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] SPACE_MAX  = 8'h20;
   localparam logic [7:0] DEL_CHAR   = 8'h7F;

   // Longest token run that one request emits.
   localparam logic [5:0] MAX_RUN = 6'd63;

   // One result of the response channel.
   typedef struct packed {
      logic [7:0] byte_out;
      logic       ok;
      logic [5:0] count;
      logic [1:0] find_status;
      logic       last;
   } rsp_type;

   // Verdict of the scan unit on one byte.
   typedef struct packed {
      logic is_space;
      logic quote;
      logic hit;
   } scan_result_type;

endpackage

// File: sv/brft_ring.sv
// Byte store of the ring FIFO: one write port, one registered read port and
// the clearing pass that zeroes every entry after reset. Imports brft_pkg.
module brft_ring
   import brft_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data,
   output logic                     clearing
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] LAST_ADDR = PW'(DEPTH - 1);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [PW-1:0] clr_addr_ff;
   logic [PW-1:0] clr_addr_in;
   logic          clearing_ff;
   logic          clearing_in;

   // The clearing pass walks the store once, one entry per cycle.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = PW'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // Store write: zeros during the clearing pass, otherwise the write port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// File: sv/brft_scan.sv
// Shared byte classifier of the tokenizer: whitespace test, quote parity and
// the stop condition of the find scan. Uses brft_pkg constants and types.
module brft_scan
   import brft_pkg::*;
(
   input  logic [7:0]      data_byte,
   input  logic            quote_state,
   output scan_result_type result
);

   // A byte is whitespace at or below the space code or at or above DEL.
   always_comb begin
      result.is_space = (data_byte <= SPACE_MAX) || (data_byte >= DEL_CHAR);
      result.quote    = quote_state ^ (data_byte == QUOTE_CHAR);
      result.hit      = !result.quote && result.is_space;
   end

endmodule

// File: sv/byte_ring_fifo_tokenizer.sv
// Byte ring FIFO with a whitespace tokenizer: sequencer, pointers and results.
// Depends on brft_pkg, brft_ring and brft_scan.
//
// A request is taken when start is high and busy is low; results come one
// per cycle on the rsp_ ports, marked by rsp_strobe, and cannot be held off.
// Put and unused actions finish in the accept cycle, get and peek go through
// a further state for the registered store read. Skip, find and token walk
// the stored bytes one per cycle through the single store read port and the
// shared classifier; token takes the skip and find walks and then streams
// one byte per cycle. Each result shows the cycle after it is formed, and
// busy drops in that cycle. After reset the store is zeroed in one pass
// over every entry, during which busy is high.
module byte_ring_fifo_tokenizer
   import brft_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [7:0] req_byte_in,
   input  logic [5:0] req_offset,
   output logic       rsp_strobe,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_ok,
   output logic [5:0] rsp_count,
   output logic [1:0] rsp_find_status,
   output logic       rsp_last
);

   localparam int PW = $clog2(DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GET  = 3'd1;
   localparam logic [2:0] S_PEEK = 3'd2;
   localparam logic [2:0] S_SKIP = 3'd3;
   localparam logic [2:0] S_FIND = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]      state_ff,    state_in;
   logic [PW-1:0]   wp_ff,       wp_in;
   logic [PW-1:0]   rp_ff,       rp_in;
   logic [PW-1:0]   idx_ff,      idx_in;
   logic            quote_ff,    quote_in;
   logic            token_ff,    token_in;
   logic [5:0]      tok_len_ff,  tok_len_in;
   logic [5:0]      emit_cnt_ff, emit_cnt_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_ff,      rsp_in;

   logic            wr_en;
   logic [PW-1:0]   wr_addr;
   logic [7:0]      wr_data;
   logic [PW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   logic            clearing;
   scan_result_type scan;

   logic [PW-1:0]   used;
   logic [PW-1:0]   idx_next;
   logic [PW-1:0]   skip_n;
   logic [15:0]     pos_wide;
   logic            full;
   logic            empty;
   logic            emit_last;

   brft_ring #(.DEPTH(DEPTH)) u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   brft_scan u_scan (
      .data_byte   (rd_data),
      .quote_state (quote_ff),
      .result      (scan)
   );

   // Occupancy and scan helpers.
   assign used      = PW'(wp_ff - rp_ff);
   assign full      = (PW'(wp_ff + 1'b1) == rp_ff);
   assign empty     = (wp_ff == rp_ff);
   assign idx_next  = PW'(idx_ff + 1'b1);
   assign skip_n    = scan.is_space ? idx_next : idx_ff;
   assign pos_wide  = 16'(idx_ff);
   assign emit_last = (6'(emit_cnt_ff + 6'd1) == tok_len_ff);
   assign busy      = clearing || (state_ff != S_IDLE);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      idx_in        = idx_ff;
      quote_in      = quote_ff;
      token_in      = token_ff;
      tok_len_in    = tok_len_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = wp_ff;
      wr_data       = req_byte_in;
      rd_addr       = rp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start && !clearing) begin
               unique case (req_action)
                  ACT_PUT: begin
                     wr_en         = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                     if (!full) begin
                        wp_in     = PW'(wp_ff + 1'b1);
                        rsp_in.ok = 1'b1;
                     end else begin
                        // Full ring: mark the newest byte as lost.
                        wr_addr = PW'(wp_ff - 1'b1);
                        wr_data = STAR_CHAR;
                     end
                  end
                  ACT_GET: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  ACT_PEEK: begin
                     rd_addr  = PW'(rp_ff + PW'(req_offset));
                     state_in = S_PEEK;
                  end
                  ACT_SKIP, ACT_TOKEN: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                     end else begin
                        idx_in   = '0;
                        token_in = (req_action == ACT_TOKEN);
                        state_in = S_SKIP;
                     end
                  end
                  ACT_FIND: begin
                     if (empty) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.find_status = FIND_EMPTY;
                        rsp_in.last        = 1'b1;
                     end else begin
                        idx_in   = '0;
                        quote_in = 1'b0;
                        token_in = 1'b0;
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end

         S_GET: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.byte_out = rd_data;
            rsp_in.ok       = 1'b1;
            rsp_in.last     = 1'b1;
            rp_in           = PW'(rp_ff + 1'b1);
            state_in        = S_IDLE;
         end

         S_PEEK: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.byte_out = rd_data;
            rsp_in.ok       = 1'b1;
            rsp_in.last     = 1'b1;
            state_in        = S_IDLE;
         end

         // Walk leading whitespace; the next address is read ahead.
         S_SKIP: begin
            if (scan.is_space && (idx_next != used)) begin
               idx_in  = idx_next;
               rd_addr = PW'(rp_ff + idx_next);
            end else begin
               rp_in = PW'(rp_ff + skip_n);
               if (!token_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.ok     = 1'b1;
                  rsp_in.count  = 6'(skip_n);
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end else if (skip_n == used) begin
                  // Only whitespace was held: no token.
                  rsp_strobe_in = 1'b1;
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = '0;
                  quote_in = 1'b0;
                  rd_addr  = PW'(rp_ff + skip_n);
                  state_in = S_FIND;
               end
            end
         end

         // Search the first whitespace outside double quotes.
         S_FIND: begin
            if (scan.hit) begin
               if (!token_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.ok     = 1'b1;
                  rsp_in.count  = 6'(idx_ff);
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end else if (idx_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  tok_len_in  = (pos_wide > 16'(MAX_RUN)) ? MAX_RUN : pos_wide[5:0];
                  emit_cnt_in = '0;
                  rd_addr     = rp_ff;
                  state_in    = S_EMIT;
               end
            end else if (idx_next == used) begin
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               if (!token_ff) begin
                  rsp_in.find_status = FIND_NONE;
               end
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_next;
               quote_in = scan.quote;
               rd_addr  = PW'(rp_ff + idx_next);
            end
         end

         // Pop and emit the token bytes, one per cycle.
         S_EMIT: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.byte_out = rd_data;
            rsp_in.ok       = 1'b1;
            rsp_in.count    = tok_len_ff;
            rsp_in.last     = emit_last;
            rp_in           = PW'(rp_ff + 1'b1);
            rd_addr         = PW'(rp_ff + 1'b1);
            emit_cnt_in     = 6'(emit_cnt_ff + 6'd1);
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= '0;
         rp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Scan and response payload registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      quote_ff    <= quote_in;
      token_ff    <= token_in;
      tok_len_ff  <= tok_len_in;
      emit_cnt_ff <= emit_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_byte_out    = rsp_ff.byte_out;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_count       = rsp_ff.count;
   assign rsp_find_status = rsp_ff.find_status;
   assign rsp_last        = rsp_ff.last;

`ifndef NO_ASSERTIONS
   // A token run that is not finished keeps streaming in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.last |=> rsp_strobe_ff)
      else $error("token run broken before its last byte");

   // The emit counter stays below the token length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (emit_cnt_ff < tok_len_ff))
      else $error("emit counter passed the token length");

   // Nothing writes the store while it is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !wr_en)
      else $error("store written during the clearing pass");

   // A put request answers in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_PUT) |=> rsp_strobe_ff && rsp_ff.last)
      else $error("put request without a response");
`endif

endmodule
